@@ sv/irpph_pkg.sv @@
// Package for the infrared pulse-pattern hash block.
// Holds the FNV-1 constants, field widths and the comparison and hash step functions.
// No dependencies.
package irpph_pkg;

  localparam int DUR_W       = 16;
  localparam int HASH_W      = 32;
  localparam int BITS_W      = 10;
  localparam int SYM_W       = 2;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 48;

  localparam logic [HASH_W-1:0] FNV_START     = 32'd2166136261;
  localparam logic [HASH_W-1:0] FNV_PRIME_LO  = 32'd403;
  localparam int                MIN_ENTRIES   = 6;
  localparam int                BIT_COUNT_MAX = 1023;

  localparam logic [SYM_W-1:0] SYM_SHORTER = 2'd0;
  localparam logic [SYM_W-1:0] SYM_EQUAL   = 2'd1;
  localparam logic [SYM_W-1:0] SYM_LONGER  = 2'd2;

  typedef logic [DUR_W-1:0]  dur_t;
  typedef logic [HASH_W-1:0] hash_t;
  typedef logic [BITS_W-1:0] bits_t;
  typedef logic [SYM_W-1:0]  sym_t;

  // 0 if 5*new < 4*old, 2 if 5*old < 4*new, else 1
  function automatic sym_t cmp_pulse(input dur_t old_d, input dur_t new_d);
    logic [DUR_W+2:0] new5;
    logic [DUR_W+2:0] old5;
    logic [DUR_W+2:0] new4;
    logic [DUR_W+2:0] old4;
    sym_t             s;
    new5 = {new_d, 2'b00} + {3'b000, new_d};
    old5 = {old_d, 2'b00} + {3'b000, old_d};
    new4 = {1'b0, new_d, 2'b00};
    old4 = {1'b0, old_d, 2'b00};
    if (new5 < old4) begin
      s = SYM_SHORTER;
    end else if (old5 < new4) begin
      s = SYM_LONGER;
    end else begin
      s = SYM_EQUAL;
    end
    return s;
  endfunction

  // prime = 2^24 + 403, product taken mod 2^32
  function automatic hash_t fnv_step(input hash_t h, input sym_t v);
    hash_t prod;
    prod = {h[7:0], 24'd0} + h * FNV_PRIME_LO;
    return prod ^ {{(HASH_W-SYM_W){1'b0}}, v};
  endfunction

endpackage

@@ sv/ir_pulse_pattern_hash.sv @@
// Infrared pulse-pattern hash: top level.
// Compares each duration with the one two entries back and folds the result into FNV-1.
// Depends on irpph_pkg.
//
// Input stream (s_*): one pulse duration per word in s_tdata, s_tlast on the final
// entry of a burst. Output stream (m_*): one word per burst, sent for the entry that
// carries s_tlast, with the hash and bit count in m_tdata and the valid flag in m_tuser.
// A burst of fewer than six entries reports valid low and a zero hash.
// Entries beyond MAX_ENTRIES are dropped, but a dropped entry with tlast still ends
// the burst.
// Path: an accepted word waits in the input register, is processed from there, and
// its result is registered into the output register that drives m_tvalid.
// Throughput: one word per cycle while no last word is stalled, set by the hash update
// (shift-add multiply by the FNV prime and xor) feeding back into the running hash register.
// While a result waits on m_tready, input words keep flowing; only a further last
// word stalls in the input register, and then s_tready drops.
// Reset (rst, synchronous) empties both registers and returns the burst state to
// zero counts and the FNV offset basis.
module ir_pulse_pattern_hash #(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [irpph_pkg::IN_TDATA_W-1:0]    s_tdata,   // [15:0] duration
  input  logic                                s_tlast,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [irpph_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [31:0] hash_value, [41:32] bit_count
  output logic                                m_tuser    // [0] valid_res
);
  import irpph_pkg::*;

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int BW = (CW > BITS_W) ? CW : BITS_W;

  logic          in_valid;
  dur_t          in_dur;
  logic          in_last;

  dur_t          older_duration;
  dur_t          newer_duration;
  logic [CW-1:0] entry_count;
  hash_t         running_hash;

  logic          out_valid;
  hash_t         out_hash;
  bits_t         out_bits;
  logic          out_ok;

  logic          proc;
  logic          take;
  logic [CW-1:0] count_next;
  hash_t         hash_next;
  logic [BW-1:0] half;
  bits_t         bits_sat;
  logic          ok;

  assign proc     = in_valid && !(in_last && out_valid && !m_tready);
  assign s_tready = !in_valid || proc;
  assign take     = entry_count < CW'(MAX_ENTRIES);

  always_comb begin
    count_next = entry_count;
    hash_next  = running_hash;
    if (take) begin
      count_next = entry_count + CW'(1);
      if (entry_count >= CW'(3)) begin
        hash_next = fnv_step(running_hash, cmp_pulse(older_duration, in_dur));
      end
    end
    half = BW'(count_next >> 1);
    if (half > BW'(BIT_COUNT_MAX)) begin
      bits_sat = BITS_W'(BIT_COUNT_MAX);
    end else begin
      bits_sat = half[BITS_W-1:0];
    end
    ok = count_next >= CW'(MIN_ENTRIES);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_dur  <= s_tdata[DUR_W-1:0];
      in_last <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      older_duration <= '0;
      newer_duration <= '0;
      entry_count    <= '0;
      running_hash   <= FNV_START;
    end else if (proc) begin
      if (in_last) begin
        older_duration <= '0;
        newer_duration <= '0;
        entry_count    <= '0;
        running_hash   <= FNV_START;
      end else begin
        if (take) begin
          older_duration <= newer_duration;
          newer_duration <= in_dur;
        end
        entry_count  <= count_next;
        running_hash <= hash_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc && in_last) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (proc && in_last) begin
      out_hash <= ok ? hash_next : '0;
      out_bits <= bits_sat;
      out_ok   <= ok;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_TDATA_W-HASH_W-BITS_W){1'b0}}, out_bits, out_hash};
  assign m_tuser  = out_ok;

  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[HASH_W-1:0] == '0)
    else $error("short burst result carries a nonzero hash");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(MAX_ENTRIES))
    else $error("entry count beyond limit");

  a_burst_clear: assert property (@(posedge clk) disable iff (rst)
    proc && in_last |=> entry_count == '0 && running_hash == FNV_START)
    else $error("burst state not cleared after result");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && in_last && m_tvalid && !m_tready)
    else $error("input stalled without a pending result");

endmodule
